// ===== rtl/bmf_pkg.sv =====
// Shared types and constants for the box mean filter.
package bmf_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxWindow  = 31;
  localparam int unsigned HeightMax  = 1024;
  localparam int unsigned StoreRows  = 32;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowSelW    = $clog2(StoreRows);
  localparam int unsigned AddrW      = ColW + RowSelW;
  localparam int unsigned PixW       = 24;
  localparam int unsigned SumW       = 18;
  localparam int unsigned AreaW      = 10;
  localparam int unsigned CntW       = 5;

  localparam logic [1:0] CfgImageWidth   = 2'd0;
  localparam logic [1:0] CfgImageHeight  = 2'd1;
  localparam logic [1:0] CfgWindowWidth  = 2'd2;
  localparam logic [1:0] CfgWindowHeight = 2'd3;

  typedef struct packed {
    logic       mode;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mean0;
    logic [7:0] mean1;
    logic [7:0] mean2;
    logic       frame_last;
  } out_item_t;

  typedef logic [SumW-1:0] sum_t;

endpackage

// ===== rtl/box_mean_filter_zero_pad.sv =====
// Box mean filter with zero padding: top level, sequencer and output register.
// Each request with mode clear is written to the line store until the whole
// frame has been taken in. When a request releases an output pixel, the
// window is read one store entry per cycle through the single read port of
// the line store, and the three sums are divided bit-serially by the 18-step
// divider; the input is stalled until that pixel is loaded into the output
// register. A finished pixel waits in the output register while the next
// request is taken. A register write restarts the frame.
module box_mean_filter_zero_pad (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bmf_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bmf_pkg::out_item_t   out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [10:0]          cfg_data_i
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StCheck = 6'b000010,
    StSum   = 6'b000100,
    StFlush = 6'b001000,
    StStart = 6'b010000,
    StDiv   = 6'b100000
  } state_e;

  state_e state_q;

  logic [10:0] img_w_q, img_h_q;
  logic [4:0]  win_w_q, win_h_q;
  logic [9:0]  in_row_q, in_col_q, out_row_q, out_col_q;
  logic        in_done_q;
  logic [4:0]  i_q, j_q;
  logic        rd_ok_q;
  bmf_pkg::sum_t sum_q [3];
  logic        out_valid_q;
  bmf_pkg::out_item_t out_q;

  logic [10:0] w, h;
  logic [4:0]  ww, wh;
  logic [3:0]  rneg, cneg;
  logic [11:0] cr, cc;
  logic        ready;
  logic        last;
  logic        in_acc, pix_wr;
  logic [10:0] in_col_inc, in_row_inc;
  logic signed [11:0] rr, col;
  logic        in_range;
  logic [bmf_pkg::PixW-1:0] rdata;
  logic        div_busy;
  logic [7:0]  quot [3];
  logic        out_load;
  logic [bmf_pkg::AreaW-1:0] area;

  assign w  = (img_w_q == '0) ? 11'd1 :
              (img_w_q > 11'(bmf_pkg::MaxWidth)) ? 11'(bmf_pkg::MaxWidth) : img_w_q;
  assign h  = (img_h_q == '0) ? 11'd1 :
              (img_h_q > 11'(bmf_pkg::HeightMax)) ? 11'(bmf_pkg::HeightMax) : img_h_q;
  assign ww = (win_w_q == '0) ? 5'd1 : win_w_q;
  assign wh = (win_h_q == '0) ? 5'd1 : win_h_q;
  assign rneg = wh[4:1];
  assign cneg = ww[4:1];
  assign area = {5'b0, ww} * {5'b0, wh};

  always_comb begin
    cr = {2'b00, out_row_q} + {7'b0, wh} - 12'd1 - {8'b0, rneg};
    if (cr > {1'b0, h} - 12'd1) cr = {1'b0, h} - 12'd1;
    cc = {2'b00, out_col_q} + {7'b0, ww} - 12'd1 - {8'b0, cneg};
    if (cc > {1'b0, w} - 12'd1) cc = {1'b0, w} - 12'd1;
  end

  assign ready = in_done_q || ({2'b00, in_row_q} > cr) ||
                 (({2'b00, in_row_q} == cr) && ({2'b00, in_col_q} > cc));
  assign last  = ({1'b0, out_row_q} == h - 11'd1) && ({1'b0, out_col_q} == w - 11'd1);

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pix_wr     = in_acc && !in_data_i.mode && !in_done_q;
  assign in_col_inc = {1'b0, in_col_q} + 11'd1;
  assign in_row_inc = {1'b0, in_row_q} + 11'd1;

  assign rr  = $signed({2'b00, out_row_q}) - $signed({8'b0, rneg}) + $signed({7'b0, i_q});
  assign col = $signed({2'b00, out_col_q}) - $signed({8'b0, cneg}) + $signed({7'b0, j_q});
  assign in_range = !rr[11] && (rr[10:0] < h) && !col[11] && (col[10:0] < w);

  bmf_line_store u_store (
    .clk_i   (clk_i),
    .we_i    (pix_wr),
    .waddr_i ({in_row_q[bmf_pkg::RowSelW-1:0], in_col_q}),
    .wdata_i ({in_data_i.chan2, in_data_i.chan1, in_data_i.chan0}),
    .raddr_i ({rr[bmf_pkg::RowSelW-1:0], col[bmf_pkg::ColW-1:0]}),
    .rdata_o (rdata)
  );

  bmf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == StStart),
    .dividend_i (sum_q),
    .divisor_i  (area),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign out_load = (state_q == StDiv) && !div_busy && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      img_w_q   <= 11'd256;
      img_h_q   <= 11'd256;
      win_w_q   <= 5'd21;
      win_h_q   <= 5'd21;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      in_done_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      rd_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmf_pkg::CfgImageWidth:   img_w_q <= cfg_data_i;
        bmf_pkg::CfgImageHeight:  img_h_q <= cfg_data_i;
        bmf_pkg::CfgWindowWidth:  win_w_q <= cfg_data_i[4:0];
        bmf_pkg::CfgWindowHeight: win_h_q <= cfg_data_i[4:0];
        default: ;
      endcase
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      in_done_q <= 1'b0;
      state_q   <= StIdle;
      rd_ok_q   <= 1'b0;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end else begin
      rd_ok_q     <= (state_q == StSum) && in_range;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (pix_wr) begin
              if (in_col_inc >= w) begin
                in_col_q <= '0;
                if (in_row_inc >= h) begin
                  in_row_q  <= '0;
                  in_done_q <= 1'b1;
                end else begin
                  in_row_q <= in_row_inc[9:0];
                end
              end else begin
                in_col_q <= in_col_inc[9:0];
              end
            end
            state_q <= StCheck;
          end
        end
        StCheck: begin
          i_q <= '0;
          j_q <= '0;
          state_q <= ready ? StSum : StIdle;
        end
        StSum: begin
          if (j_q == ww - 5'd1) begin
            j_q <= '0;
            if (i_q == wh - 5'd1) begin
              state_q <= StFlush;
            end else begin
              i_q <= i_q + 5'd1;
            end
          end else begin
            j_q <= j_q + 5'd1;
          end
        end
        StFlush: state_q <= StStart;
        StStart: state_q <= StDiv;
        StDiv: begin
          if (out_load) begin
            state_q <= StIdle;
            if (last) begin
              in_row_q  <= '0;
              in_col_q  <= '0;
              out_row_q <= '0;
              out_col_q <= '0;
              in_done_q <= 1'b0;
            end else if ({1'b0, out_col_q} + 11'd1 >= w) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + 10'd1;
            end else begin
              out_col_q <= out_col_q + 10'd1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StCheck) begin
      for (int k = 0; k < 3; k++) sum_q[k] <= '0;
    end else if (rd_ok_q) begin
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= sum_q[k] + bmf_pkg::sum_t'(rdata[8*k +: 8]);
      end
    end
    if (out_load) begin
      out_q.mean0      <= quot[0];
      out_q.mean1      <= quot[1];
      out_q.mean2      <= quot[2];
      out_q.frame_last <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/bmf_line_store.sv =====
// Line store: one write port and one registered read port.
module bmf_line_store (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [bmf_pkg::AddrW-1:0]           waddr_i,
  input  logic [bmf_pkg::PixW-1:0]            wdata_i,
  input  logic [bmf_pkg::AddrW-1:0]           raddr_i,
  output logic [bmf_pkg::PixW-1:0]            rdata_o
);

  logic [bmf_pkg::PixW-1:0] mem_q [2**bmf_pkg::AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/bmf_div.sv =====
// Three-lane restoring divider, one quotient bit per cycle.
module bmf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  bmf_pkg::sum_t               dividend_i [3],
  input  logic [bmf_pkg::AreaW-1:0]   divisor_i,
  output logic                        busy_o,
  output logic [7:0]                  quot_o [3]
);

  bmf_pkg::sum_t             quo_q [3];
  bmf_pkg::sum_t             quo_d [3];
  logic [bmf_pkg::AreaW-1:0] rem_q [3];
  logic [bmf_pkg::AreaW-1:0] rem_d [3];
  logic [bmf_pkg::AreaW-1:0] div_q;
  logic [bmf_pkg::CntW-1:0]  cnt_q;
  logic                      busy_q;

  always_comb begin
    logic [bmf_pkg::AreaW:0]   shifted;
    logic [bmf_pkg::AreaW+1:0] trial;
    for (int k = 0; k < 3; k++) begin
      shifted = {rem_q[k], quo_q[k][bmf_pkg::SumW-1]};
      trial   = {1'b0, shifted} - {2'b00, div_q};
      if (!trial[bmf_pkg::AreaW+1]) begin
        rem_d[k] = trial[bmf_pkg::AreaW-1:0];
        quo_d[k] = {quo_q[k][bmf_pkg::SumW-2:0], 1'b1};
      end else begin
        rem_d[k] = shifted[bmf_pkg::AreaW-1:0];
        quo_d[k] = {quo_q[k][bmf_pkg::SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= bmf_pkg::CntW'(bmf_pkg::SumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == bmf_pkg::CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      for (int k = 0; k < 3; k++) begin
        quo_q[k] <= dividend_i[k];
        rem_q[k] <= '0;
      end
    end else if (busy_q) begin
      for (int k = 0; k < 3; k++) begin
        quo_q[k] <= quo_d[k];
        rem_q[k] <= rem_d[k];
      end
    end
  end

  assign busy_o = busy_q;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quot_o[k] = quo_q[k][7:0];
    end
  end

endmodule
